FILE: rtl/hcfe_pkg.sv
// Shared types and constants for the hex command frame encoder.
`default_nettype none
package hcfe_pkg;

    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    typedef enum logic [2:0] {
        SEL_COLON,
        SEL_DATA_HI,
        SEL_DATA_LO,
        SEL_CHK_HI,
        SEL_CHK_LO,
        SEL_NEWLINE
    } char_sel_t;

    typedef struct packed {
        logic      load;
        logic      emit;
        char_sel_t sel;
        logic      eor;
    } hcfe_cmd_t;

    typedef struct packed {
        logic in_first;
        logic last;
        logic final_byte;
        logic out_free;
    } hcfe_status_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end
        else begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/hex_command_frame_encoder_core.sv
// Top level of the hex command frame encoder: sequencer plus datapath.
// The first character of a request is registered once the sequencer has left idle and the
// output register is free. A request gives 2 to 12 characters; a new one waits for idle.
// One character per cycle goes out through one output register while out_ready is high.
// Reset (rst_n low, asynchronous): sequencer idle, output empty, byte sum zero.
`default_nettype none
module hex_command_frame_encoder_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] field_value,
    input  wire logic [1:0]  field_size,
    input  wire logic        first_field,
    input  wire logic        last_field,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       char_out,
    output logic             end_of_run
);
    import hcfe_pkg::*;

    hcfe_cmd_t    cmd;
    hcfe_status_t st;

    // Sequencer: take a request when idle, then advance one character each
    // time the output register frees up; drop back to idle on the final one.
    hcfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // Datapath: hold the field, pick bytes low first, keep the frame sum,
    // and register each ASCII character for the consumer.
    hcfe_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .field_value (field_value),
        .field_size  (field_size),
        .first_field (first_field),
        .last_field  (last_field),
        .char_out    (char_out),
        .end_of_run  (end_of_run),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cmd         (cmd),
        .st          (st)
    );

endmodule
`default_nettype wire

FILE: rtl/hcfe_ctrl.sv
// Sequencer: colon if first field, data bytes, checksum and newline if last.
`default_nettype none
module hcfe_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire hcfe_pkg::hcfe_status_t st,
    output hcfe_pkg::hcfe_cmd_t        cmd
);
    import hcfe_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COLON,
        S_DHI,
        S_DLO,
        S_CHI,
        S_CLO,
        S_NL
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        cmd.sel    = SEL_COLON;
        cmd.eor    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = st.in_first ? S_COLON : S_DHI;
                end
            end
            S_COLON:
            begin
                cmd.sel = SEL_COLON;
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_DHI;
                end
            end
            S_DHI:
            begin
                cmd.sel = SEL_DATA_HI;
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_DLO;
                end
            end
            S_DLO:
            begin
                cmd.sel = SEL_DATA_LO;
                cmd.eor = st.final_byte && !st.last;
                if (st.out_free) begin
                    cmd.emit = 1'b1;
                    if (!st.final_byte) begin
                        state_next = S_DHI;
                    end
                    else if (st.last) begin
                        state_next = S_CHI;
                    end
                    else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_CHI:
            begin
                cmd.sel = SEL_CHK_HI;
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_CLO;
                end
            end
            S_CLO:
            begin
                cmd.sel = SEL_CHK_LO;
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_NL;
                end
            end
            S_NL:
            begin
                cmd.sel = SEL_NEWLINE;
                cmd.eor = 1'b1;
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/hcfe_dp.sv
// Datapath: field hold, byte select, running sum, hex conversion, output register.
`default_nettype none
module hcfe_dp (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [31:0]           field_value,
    input  wire logic [1:0]            field_size,
    input  wire logic                  first_field,
    input  wire logic                  last_field,
    output logic [7:0]                 char_out,
    output logic                       end_of_run,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire hcfe_pkg::hcfe_cmd_t   cmd,
    output hcfe_pkg::hcfe_status_t     st
);
    import hcfe_pkg::*;

    logic [31:0] value_reg;
    logic [1:0]  last_idx_reg;
    logic [1:0]  idx_reg;
    logic        last_reg;
    logic [7:0]  sum_reg;
    logic [7:0]  char_reg;
    logic        eor_reg;
    logic        valid_reg;
    logic [7:0]  cur_byte;
    logic [7:0]  check;
    logic [7:0]  char_next;

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur_byte = value_reg[7:0];
            2'd1:    cur_byte = value_reg[15:8];
            2'd2:    cur_byte = value_reg[23:16];
            default: cur_byte = value_reg[31:24];
        endcase
    end

    assign check = 8'd0 - sum_reg;

    always_comb
    begin
        case (cmd.sel)
            SEL_COLON:   char_next = CHAR_COLON;
            SEL_DATA_HI: char_next = hex_char(cur_byte[7:4]);
            SEL_DATA_LO: char_next = hex_char(cur_byte[3:0]);
            SEL_CHK_HI:  char_next = hex_char(check[7:4]);
            SEL_CHK_LO:  char_next = hex_char(check[3:0]);
            default:     char_next = CHAR_NEWLINE;
        endcase
    end

    assign st.in_first   = first_field;
    assign st.last       = last_reg;
    assign st.final_byte = (idx_reg == last_idx_reg);
    assign st.out_free   = !valid_reg || out_ready;

    assign char_out   = char_reg;
    assign end_of_run = eor_reg;
    assign out_valid  = valid_reg;

    // Hold the field, track the next byte, and register each character and end flag.
    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            value_reg <= field_value;
            last_reg  <= last_field;
            idx_reg   <= 2'd0;
            case (field_size)
                2'd0:    last_idx_reg <= 2'd0;
                2'd1:    last_idx_reg <= 2'd1;
                default: last_idx_reg <= 2'd3;
            endcase
        end
        else if (cmd.emit && cmd.sel == SEL_DATA_LO) begin
            idx_reg <= idx_reg + 2'd1;
        end
        if (cmd.emit) begin
            char_reg <= char_next;
            eor_reg  <= cmd.eor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sum_reg   <= 8'd0;
            valid_reg <= 1'b0;
        end
        else begin
            if (cmd.load && first_field) begin
                sum_reg <= 8'd0;
            end
            else if (cmd.emit && cmd.sel == SEL_DATA_LO) begin
                sum_reg <= sum_reg + cur_byte;
            end
            else if (cmd.emit && cmd.sel == SEL_NEWLINE) begin
                sum_reg <= 8'd0;
            end
            if (cmd.emit) begin
                valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire
